FILE: hw/rtl/gop_pkg.sv
`timescale 1ns / 1ps

package gop_pkg;

  localparam logic [7:0] CharG     = 8'h47;
  localparam logic [7:0] CharM     = 8'h4D;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [2:0] PosSign  = 3'd3;
  localparam logic [2:0] PosFirst = 3'd4;
  localparam logic [2:0] PosBody  = 3'd5;

  localparam int unsigned MaxHours   = 23;
  localparam int unsigned MaxMinutes = 59;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [11:0] offset_minutes;
    logic               minus_sign;
    logic [4:0]         hour_part;
    logic [5:0]         minute_part;
  } res_item_t;

endpackage

FILE: hw/rtl/gmt_offset_id_parser.sv
`timescale 1ns / 1ps

// custom gmt offset zone id parser (GMT+h, GMT-hhmm, GMT+hh:mm and so on)
// char channel: one ascii character per transfer, last marks the end of an id
// res channel: one result transfer per id, issued for its last character
// the result is registered after the last character's transfer, through the
//   id state registers, then the result register
// throughput: one character per cycle while char_stall is low; the state update is a
//   single digit shift and small compare, the result path one 5x6 bit multiply and add
// the id state clears in the same cycle its result moves to the result
//   register, so the next id can start right behind the previous one
// when res_stall holds a result and another finished id waits behind it,
//   char_stall goes high until the result register frees up
// reset clears the id state and drops res_valid; no clearing pass is needed
// an id too short, with a bad prefix, sign or character, or out of range
//   gives valid_res low and all other fields zero

module gmt_offset_id_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  gop_pkg::char_item_t   char_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output gop_pkg::res_item_t    res_item
);
  import gop_pkg::*;

  // id state
  logic [2:0] pos;
  logic       err;
  logic       neg;
  logic       colon;
  logic [1:0] count;
  logic [6:0] held;
  logic [4:0] hi;
  logic       hi_over;
  logic [3:0] tens;
  logic [3:0] units;
  logic       pend;

  logic [2:0] pos_next;
  logic       err_next;
  logic       neg_next;
  logic       colon_next;
  logic [1:0] count_next;
  logic [6:0] held_next;
  logic [4:0] hi_next;
  logic       hi_over_next;
  logic [3:0] tens_next;
  logic [3:0] units_next;

  logic       accept;
  logic       go;
  logic [7:0] hi_calc;
  logic [6:0] two_digits;
  logic       is_digit;

  // result path
  logic        ok;
  logic [6:0]  hours;
  logic [6:0]  minutes;
  logic [10:0] total;
  logic [11:0] offset;
  res_item_t   res_calc;

  assign go         = pend && (!res_valid || !res_stall);
  assign char_stall = pend && res_valid && res_stall;
  assign accept     = char_valid && !char_stall;

  assign two_digits = 7'(tens) * 7'd10 + 7'(units);
  assign is_digit   = (char_item.ch >= CharZero) && (char_item.ch <= CharNine);

  always_comb begin
    if (pend) begin
      pos_next     = '0;
      err_next     = 1'b0;
      neg_next     = 1'b0;
      colon_next   = 1'b0;
      count_next   = '0;
      held_next    = '0;
      hi_next      = '0;
      hi_over_next = 1'b0;
      tens_next    = '0;
      units_next   = '0;
    end else begin
      pos_next     = pos;
      err_next     = err;
      neg_next     = neg;
      colon_next   = colon;
      count_next   = count;
      held_next    = held;
      hi_next      = hi;
      hi_over_next = hi_over;
      tens_next    = tens;
      units_next   = units;
    end
    hi_calc = 8'(hi_next * 8'd10) + 8'(tens_next);
    if (accept) begin
      case (pos_next)
        3'd0: begin
          if (char_item.ch != CharG) err_next = 1'b1;
          pos_next = 3'd1;
        end
        3'd1: begin
          if (char_item.ch != CharM) err_next = 1'b1;
          pos_next = 3'd2;
        end
        3'd2: begin
          if (char_item.ch != CharT) err_next = 1'b1;
          pos_next = PosSign;
        end
        PosSign: begin
          if (char_item.ch == CharMinus) neg_next = 1'b1;
          else if (char_item.ch != CharPlus) err_next = 1'b1;
          pos_next = PosFirst;
        end
        default: begin
          pos_next = PosBody;
          if (char_item.ch == CharColon) begin
            if (colon_next || (count_next == 2'd3)) begin
              err_next = 1'b1;
            end else begin
              held_next    = 7'(tens_next) * 7'd10 + 7'(units_next);
              colon_next   = 1'b1;
              count_next   = '0;
              hi_next      = '0;
              hi_over_next = 1'b0;
              tens_next    = '0;
              units_next   = '0;
            end
          end else if (is_digit) begin
            hi_over_next = hi_over_next || (hi_calc > 8'(MaxHours));
            hi_next      = hi_calc[4:0];
            tens_next    = units_next;
            units_next   = char_item.ch[3:0];
            if (count_next != 2'd3) count_next = count_next + 2'd1;
          end else begin
            err_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    ok      = !err && (pos == PosBody);
    hours   = '0;
    minutes = '0;
    if (colon) begin
      if (count != 2'd2) ok = 1'b0;
      hours   = held;
      minutes = two_digits;
    end else if (count != 2'd3) begin
      hours = two_digits;
    end else begin
      if (hi_over) ok = 1'b0;
      hours   = 7'(hi);
      minutes = two_digits;
    end
    if ((hours > 7'(MaxHours)) || (minutes > 7'(MaxMinutes))) ok = 1'b0;
    if (!ok) begin
      hours   = '0;
      minutes = '0;
    end
    total  = 11'(hours[4:0] * 11'd60) + 11'(minutes[5:0]);
    offset = (ok && neg) ? 12'(12'd0 - 12'(total)) : 12'(total);
    res_calc.valid_res      = ok;
    res_calc.offset_minutes = offset;
    res_calc.minus_sign     = ok && neg;
    res_calc.hour_part      = hours[4:0];
    res_calc.minute_part    = minutes[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      err       <= 1'b0;
      neg       <= 1'b0;
      colon     <= 1'b0;
      count     <= '0;
      held      <= '0;
      hi        <= '0;
      hi_over   <= 1'b0;
      tens      <= '0;
      units     <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept || go) begin
        pos     <= pos_next;
        err     <= err_next;
        neg     <= neg_next;
        colon   <= colon_next;
        count   <= count_next;
        held    <= held_next;
        hi      <= hi_next;
        hi_over <= hi_over_next;
        tens    <= tens_next;
        units   <= units_next;
        pend    <= accept && char_item.last;
      end
      if (go) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_item <= res_calc;
    end
  end

endmodule
